// ===== design/first_fit_heap_allocator_unit_assert.svh =====
// assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// clocked check, off while reset is high
`define FFHA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ffha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
`default_nettype none
package ffha_pkg;

  localparam int MaxSegmentsDefault = 64;
  localparam int HeaderBytesDefault = 24;
  localparam logic [31:0] HeapBytesReset = 32'd65536;
  localparam logic [31:0] MinSplitBytes = 32'd16;

  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_BADFREE = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] request_bytes;
    logic [47:0] release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] granted_address;
    logic [31:0] total_bytes;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
  } rsp_t;

  typedef struct packed {
    logic        used;
    logic [31:0] size;
    logic [31:0] offset;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FNEXT,
    S_FMERGE,
    S_SHIFT,
    S_WRA,
    S_WRB,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== design/first_fit_heap_allocator_unit.sv =====
// first-fit heap allocator: segment table in one memory, walked per item
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_ready  | in_data  (cmd, request_bytes, release_address)
//  out     | out       | out_valid / out_ready| out_data (status, address, heap statistics)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// allocate: accept, scan up to the first fitting free segment, then one or two writes and the result
// a split below the last entry first shifts the later entries up
// free: accept, scan up to the hit, merge with free neighbours, shift later entries down, then the result
// a zero-size allocate or a null free goes straight to the result
// reset or a config write to heap base or heap bytes rebuilds the table in S_INIT, no item taken then
// a stalled result holds the block in its last state until taken
`default_nettype none
`include "first_fit_heap_allocator_unit_assert.svh"
module first_fit_heap_allocator_unit #(
  parameter int MAX_SEGMENTS = ffha_pkg::MaxSegmentsDefault,
  parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ffha_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffha_pkg::rsp_t     out_data,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [47:0]   cfg_data
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] Hdr32 = 32'(HEADER_BYTES);
  localparam logic [47:0] Hdr48 = 48'(HEADER_BYTES);
  localparam logic [33:0] SplitExtra = 34'(HEADER_BYTES) + 34'(MinSplitBytes);
  localparam logic [CW-1:0] CountMax = CW'(MAX_SEGMENTS);

  seg_t mem [MAX_SEGMENTS];

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [47:0] base;
  logic [31:0] hbytes;
  logic [31:0] used_b, free_b;
  logic cmd_r;
  logic [32:0] need;
  logic [47:0] tgt;
  logic [CW-1:0] scan_idx;
  logic rd_vld;
  logic [IW-1:0] rd_idx;
  seg_t rd_data;
  seg_t prev, cur;
  logic [IW-1:0] f_idx;
  logic has_next;
  logic [IW-1:0] wa_addr, wb_addr;
  seg_t wa_data, wb_data;
  logic has_b;
  logic [IW-1:0] sh_idx, sh_last;
  logic sh_up;
  logic [1:0] sh_r;
  logic sh_issuing;
  logic [1:0] res_status;
  logic [47:0] res_addr;

  // memory control
  logic rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  seg_t wr_data;

  // scan decode
  logic is_last, alloc_hit, free_hit, split, scan_stop;
  logic [31:0] size0;
  // merge decode
  logic nm, pm;
  logic [1:0] mr;
  logic [31:0] msize;
  logic [CW-1:0] mstart;

  assign size0 = (hbytes > Hdr32) ? hbytes - Hdr32 : 32'd0;
  assign is_last = (CW'(rd_idx) == count - CW'(1));
  assign alloc_hit = !rd_data.used && ({1'b0, rd_data.size} >= need);
  assign free_hit = ({16'd0, rd_data.offset} == tgt);
  assign split = ({2'b00, rd_data.size} >= ({1'b0, need} + SplitExtra));
  assign scan_stop = rd_vld &&
                     ((cmd_r == CMD_ALLOC) ? alloc_hit : free_hit || is_last) ||
                     rd_vld && is_last;

  assign nm = has_next && !rd_data.used;
  assign pm = (f_idx != '0) && !prev.used;
  assign mr = {1'b0, nm} + {1'b0, pm};
  assign msize = cur.size + (nm ? Hdr32 + rd_data.size : 32'd0);
  assign mstart = (pm ? CW'(f_idx) : CW'(f_idx) + CW'(1)) + CW'(mr);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        wr_en = 1'b1;
        wr_data = '{used: 1'b0, size: size0, offset: 32'd0};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_ALLOC && in_data.request_bytes == 32'd0) begin
            state_next = S_FIN;
          end else if (in_data.cmd == CMD_FREE && in_data.release_address == 48'd0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = (scan_idx < count) && !scan_stop;
        rd_addr = scan_idx[IW-1:0];
        if (rd_vld) begin
          if (cmd_r == CMD_ALLOC) begin
            if (alloc_hit) begin
              if (split && count != CountMax && CW'(rd_idx) + CW'(1) < count) begin
                state_next = S_SHIFT;
              end else begin
                state_next = S_WRA;
              end
            end else if (is_last) begin
              state_next = S_FIN;
            end
          end else begin
            if (free_hit) begin
              state_next = (CW'(rd_idx) + CW'(1) < count) ? S_FNEXT : S_FMERGE;
            end else if (is_last) begin
              state_next = S_FIN;
            end
          end
        end
      end
      S_FNEXT: begin
        rd_en = 1'b1;
        rd_addr = f_idx + IW'(1);
        state_next = S_FMERGE;
      end
      S_FMERGE: begin
        wr_en = 1'b1;
        if (pm) begin
          wr_addr = f_idx - IW'(1);
          wr_data = '{used: 1'b0, size: prev.size + Hdr32 + msize, offset: prev.offset};
        end else begin
          wr_addr = f_idx;
          wr_data = '{used: 1'b0, size: msize, offset: cur.offset};
        end
        state_next = (mr != 2'd0 && mstart < count) ? S_SHIFT : S_FIN;
      end
      S_SHIFT: begin
        rd_en = sh_issuing;
        rd_addr = sh_idx;
        wr_en = rd_vld;
        wr_addr = sh_up ? rd_idx + IW'(1) : rd_idx - IW'(sh_r);
        wr_data = rd_data;
        if (!sh_issuing && !rd_vld) begin
          state_next = sh_up ? S_WRA : S_FIN;
        end
      end
      S_WRA: begin
        wr_en = 1'b1;
        wr_addr = wa_addr;
        wr_data = wa_data;
        state_next = has_b ? S_WRB : S_FIN;
      end
      S_WRB: begin
        wr_en = 1'b1;
        wr_addr = wb_addr;
        wr_data = wb_data;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
    if (cfg_we && (cfg_index == CFG_HEAP_BASE || cfg_index == CFG_HEAP_BYTES)) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // segment memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      sh_issuing <= 1'b0;
      out_valid <= 1'b0;
      base <= 48'd0;
      hbytes <= HeapBytesReset;
      count <= CW'(1);
    end else begin
      rd_vld <= rd_en;
      rd_idx <= rd_addr;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BASE: base <= cfg_data;
          CFG_HEAP_BYTES: hbytes <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          count <= CW'(1);
          used_b <= 32'd0;
          free_b <= size0;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_data.cmd;
            need <= ({1'b0, in_data.request_bytes} + 33'd7) & ~33'd7;
            tgt <= in_data.release_address - base - Hdr48;
            scan_idx <= '0;
            res_addr <= 48'd0;
            res_status <= (in_data.cmd == CMD_ALLOC) ? STAT_FAIL : STAT_OK;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (rd_vld) begin
            if (cmd_r == CMD_ALLOC) begin
              if (alloc_hit) begin
                res_addr <= base + {16'd0, rd_data.offset} + Hdr48;
                wa_addr <= rd_idx;
                if (split && count != CountMax) begin
                  res_status <= STAT_OK;
                  used_b <= used_b + need[31:0];
                  free_b <= free_b - need[31:0] - Hdr32;
                  wa_data <= '{used: 1'b1, size: need[31:0], offset: rd_data.offset};
                  wb_addr <= rd_idx + IW'(1);
                  wb_data <= '{used: 1'b0, size: rd_data.size - need[31:0] - Hdr32,
                               offset: rd_data.offset + Hdr32 + need[31:0]};
                  has_b <= 1'b1;
                  sh_idx <= IW'(count - CW'(1));
                  sh_last <= rd_idx + IW'(1);
                  sh_up <= 1'b1;
                  sh_issuing <= 1'b1;
                end else begin
                  res_status <= split ? STAT_FULL : STAT_OK;
                  used_b <= used_b + rd_data.size;
                  free_b <= free_b - rd_data.size;
                  wa_data <= '{used: 1'b1, size: rd_data.size, offset: rd_data.offset};
                  has_b <= 1'b0;
                end
              end
            end else begin
              if (free_hit) begin
                cur <= rd_data;
                f_idx <= rd_idx;
                has_next <= (CW'(rd_idx) + CW'(1) < count);
                if (rd_data.used) begin
                  used_b <= used_b - rd_data.size;
                  free_b <= free_b + rd_data.size;
                end
              end else begin
                prev <= rd_data;
                if (is_last) begin
                  res_status <= STAT_BADFREE;
                end
              end
            end
          end
        end
        S_FMERGE: begin
          free_b <= free_b + (mr[1] ? Hdr32 + Hdr32 : (mr[0] ? Hdr32 : 32'd0));
          count <= count - CW'(mr);
          sh_idx <= IW'(mstart);
          sh_last <= IW'(count - CW'(1));
          sh_up <= 1'b0;
          sh_r <= mr;
          sh_issuing <= (mr != 2'd0 && mstart < count);
        end
        S_SHIFT: begin
          if (sh_issuing) begin
            if (sh_idx == sh_last) begin
              sh_issuing <= 1'b0;
            end else begin
              sh_idx <= sh_up ? sh_idx - IW'(1) : sh_idx + IW'(1);
            end
          end
        end
        S_WRB: begin
          count <= count + CW'(1);
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data <= '{status: res_status, granted_address: res_addr,
                          total_bytes: hbytes, used_bytes: used_b, free_bytes: free_b};
          end
        end
        default: ;
      endcase
    end
  end

  // table never empty and never past its depth
  `FFHA_ASSERT(a_count_range, clk, rst, (count != '0 && count <= CountMax), "segment count out of range")
  // an accepted item always starts work
  `FFHA_ASSERT(a_accept_busy, clk, rst, (in_valid && in_ready |=> state != S_IDLE), "accepted item left block idle")
  // headers plus payloads cover the heap whenever the block rests with a heap larger than one header
  `FFHA_ASSERT(a_bytes_conserved, clk, rst, (state == S_IDLE && hbytes > Hdr32 |-> used_b + free_b + 32'(count) * Hdr32 == hbytes), "byte accounting broken")
  // a move never reads the entry it writes in the same cycle
  `FFHA_ASSERT(a_no_rw_clash, clk, rst, (rd_en && wr_en |-> rd_addr != wr_addr), "read and write hit one entry")

endmodule
`default_nettype wire

// ===== dv/first_fit_heap_allocator_checker.sv =====
// checker for the first-fit heap allocator: shadow segment table and result compare
module first_fit_heap_allocator_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ffha_pkg::req_t in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ffha_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [47:0]    cfg_data,
  output int             mismatches,
  output int             pending
);
  import ffha_pkg::*;

  localparam int NSEG = MaxSegmentsDefault;
  localparam int HDR = HeaderBytesDefault;

  logic [47:0] base_q;
  logic [31:0] heap_q;
  logic [63:0] seg_off [NSEG];
  logic [63:0] seg_len [NSEG];
  logic        seg_busy [NSEG];
  int          seg_n;
  rsp_t        expected_rsp [$];

  function automatic logic [47:0] payload_of(int i);
    logic [63:0] a;
    a = {16'd0, base_q} + seg_off[i] + HDR;
    return a[47:0];
  endfunction

  task automatic rebuild_table();
    for (int i = 0; i < NSEG; i++) begin
      seg_off[i] = '0;
      seg_len[i] = '0;
      seg_busy[i] = 1'b0;
    end
    seg_len[0] = (heap_q > HDR) ? heap_q - HDR : 0;
    seg_n = 1;
  endtask

  task automatic drop_entry(int i);
    for (int k = i; k + 1 < seg_n; k++) begin
      seg_off[k] = seg_off[k+1];
      seg_len[k] = seg_len[k+1];
      seg_busy[k] = seg_busy[k+1];
    end
    seg_n--;
  endtask

  task automatic allocate(input logic [31:0] req, output logic [1:0] st,
                          output logic [47:0] addr);
    logic [63:0] need;
    st = STAT_FAIL;
    addr = '0;
    if (req == 0) return;
    need = ({32'd0, req} + 7) & ~64'd7;
    for (int i = 0; i < seg_n; i++) begin
      if (seg_busy[i] || seg_len[i] < need) continue;
      seg_busy[i] = 1'b1;
      addr = payload_of(i);
      st = STAT_OK;
      if (seg_len[i] >= need + HDR + 16) begin
        if (seg_n >= NSEG) begin
          st = STAT_FULL;
          return;
        end
        for (int k = seg_n; k > i + 1; k--) begin
          seg_off[k] = seg_off[k-1];
          seg_len[k] = seg_len[k-1];
          seg_busy[k] = seg_busy[k-1];
        end
        seg_off[i+1] = seg_off[i] + HDR + need;
        seg_len[i+1] = seg_len[i] - need - HDR;
        seg_busy[i+1] = 1'b0;
        seg_len[i] = need;
        seg_n++;
      end
      return;
    end
  endtask

  task automatic release_seg(input logic [47:0] addr, output logic [1:0] st);
    int i;
    st = STAT_OK;
    if (addr == 0) return;
    for (i = 0; i < seg_n; i++)
      if (payload_of(i) == addr) break;
    if (i >= seg_n) begin
      st = STAT_BADFREE;
      return;
    end
    seg_busy[i] = 1'b0;
    if (i + 1 < seg_n && !seg_busy[i+1]) begin
      seg_len[i] += HDR + seg_len[i+1];
      drop_entry(i + 1);
    end
    if (i > 0 && !seg_busy[i-1]) begin
      seg_len[i-1] += HDR + seg_len[i];
      drop_entry(i);
    end
  endtask

  task automatic predict_result(input req_t r);
    rsp_t e;
    logic [63:0] u, f;
    e = '0;
    if (r.cmd == CMD_ALLOC) allocate(r.request_bytes, e.status, e.granted_address);
    else release_seg(r.release_address, e.status);
    u = 0;
    f = 0;
    for (int i = 0; i < seg_n; i++)
      if (seg_busy[i]) u += seg_len[i];
      else f += seg_len[i];
    e.total_bytes = heap_q;
    e.used_bytes = u[31:0];
    e.free_bytes = f[31:0];
    expected_rsp.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      base_q = '0;
      heap_q = HeapBytesReset;
      rebuild_table();
      expected_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          base_q = cfg_data;
          rebuild_table();
        end else if (cfg_index == CFG_HEAP_BYTES) begin
          heap_q = cfg_data[31:0];
          rebuild_table();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected item", out_data.status, 0);
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          if (out_data.status !== e.status)
            report_mismatch("status", out_data.status, e.status);
          if (out_data.granted_address !== e.granted_address)
            report_mismatch("granted_address", out_data.granted_address, e.granted_address);
          if (out_data.total_bytes !== e.total_bytes)
            report_mismatch("total_bytes", out_data.total_bytes, e.total_bytes);
          if (out_data.used_bytes !== e.used_bytes)
            report_mismatch("used_bytes", out_data.used_bytes, e.used_bytes);
          if (out_data.free_bytes !== e.free_bytes)
            report_mismatch("free_bytes", out_data.free_bytes, e.free_bytes);
        end
      end
      if (in_valid && in_ready) predict_result(in_data);
    end
  end
endmodule

// ===== dv/testbench.sv =====
// stimulus and verdict for the first-fit heap allocator
module testbench;
  import ffha_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HEAP_BASE;
  logic [47:0] cfg_data = '0;
  int          mismatches, pending;
  int          quiet_cycles = 0;
  logic [47:0] live_addr [$];
  logic [47:0] cur_base = '0;
  int          stall_mode = 0;

  localparam int QuietLimit = 2000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_fit_heap_allocator_unit u_top (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  first_fit_heap_allocator_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .pending
  );

  // receiver stall pattern, switching between always ready, light and heavy stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // collect granted addresses so frees mostly hit real segments
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && out_data.granted_address != 0)
      live_addr.push_back(out_data.granted_address);
  end

  // cycles since the last accepted item on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_item(req_t r);
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    // the block is busy on the next edge anyway
    @(posedge clk);
  endtask

  task automatic send_gap();
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_alloc(logic [31:0] n);
    req_t r;
    r = '0;
    r.cmd = CMD_ALLOC;
    r.request_bytes = n;
    r.release_address = 48'({$urandom, $urandom});
    send_item(r);
  endtask

  task automatic send_free(logic [47:0] a);
    req_t r;
    r = '0;
    r.cmd = CMD_FREE;
    r.release_address = a;
    r.request_bytes = $urandom;
    send_item(r);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (2 * MaxSegmentsDefault + 16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    live_addr.delete();
    if (idx == CFG_HEAP_BASE) cur_base = v;
  endtask

  task automatic random_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      int burst;
      burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (burst == 0) send_gap();
      for (int b = 0; b < burst && left > 0; b++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_alloc($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 600));
        end else if (pick < 85 && live_addr.size() != 0) begin
          int k;
          k = $urandom_range(0, live_addr.size() - 1);
          send_free(live_addr[k]);
          live_addr.delete(k);
        end else if (pick < 92) begin
          send_free(48'({$urandom, $urandom}));
        end else if (pick < 96) begin
          send_free(cur_base + HeaderBytesDefault + 8 * $urandom_range(0, 64));
        end else begin
          send_alloc($urandom_range(1, 40));
        end
        left--;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero size, huge, null and bad frees
    send_alloc(0);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(1);
    send_alloc(8);
    send_alloc(65536 - 24);
    send_free(48'd0);
    send_free(48'hFFFF_FFFF_FFFF);
    send_free(48'd24);
    send_free(48'd24);
    send_free(48'd5);
    drain();
    foreach (live_addr[i]) send_free(live_addr[i]);
    live_addr.delete();
    // fill the table so a split is refused
    for (int i = 0; i < 66; i++) send_alloc(8);
    send_alloc(200);
    drain();

    // tiny heaps: a 32-byte heap has room for one small payload, a 20-byte heap for none
    write_reg(CFG_HEAP_BYTES, 48'd32);
    send_alloc(1);
    send_alloc(8);
    drain();
    write_reg(CFG_HEAP_BYTES, 48'd20);
    send_alloc(1);
    send_free(48'd24);
    drain();

    // top of the address space wraps payload addresses
    write_reg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FFF0);
    write_reg(CFG_HEAP_BYTES, 48'd4096);
    random_phase(120);
    drain();

    write_reg(CFG_HEAP_BYTES, 48'hFFFF_FFFF);
    send_alloc(32'hFFFF_FFF0);
    random_phase(80);
    drain();

    write_reg(CFG_HEAP_BASE, 48'({$urandom, $urandom}));
    write_reg(CFG_HEAP_BYTES, 48'd2048);
    random_phase(300);
    drain();

    write_reg(CFG_HEAP_BASE, 48'h0000_1000_0000);
    write_reg(CFG_HEAP_BYTES, 48'd65536);
    random_phase(330);
    drain();

    write_reg(CFG_HEAP_BASE, 48'd0);
    write_reg(CFG_HEAP_BYTES, 48'd600);
    random_phase(100);
    drain();

    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
